FILE: rtl/ookpw_pkg.sv
// ----------------------------------------------------------------------------
// ookpw_pkg
// Types and constants shared by the pulse-width code transmitter.
// ----------------------------------------------------------------------------
package ookpw_pkg;

	localparam int MAX_CODE_BITS = 24;
	localparam int TIMER_BITS    = 16;
	localparam int POS_BITS      = $clog2(MAX_CODE_BITS);
	localparam int LEN_BITS      = 5;
	localparam int REP_BITS      = 4;
	localparam int CFG_IDX_BITS  = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ONE_HIGH  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ONE_LOW   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_HIGH = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_HIGH = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_LOW  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEATS   = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_CODE_LEN  = 3'd7;

	// Reset values of the registers
	localparam logic [TIMER_BITS-1:0] RST_ONE_HIGH  = 16'd1200;
	localparam logic [TIMER_BITS-1:0] RST_ONE_LOW   = 16'd500;
	localparam logic [TIMER_BITS-1:0] RST_ZERO_HIGH = 16'd350;
	localparam logic [TIMER_BITS-1:0] RST_ZERO_LOW  = 16'd1300;
	localparam logic [TIMER_BITS-1:0] RST_SYNC_HIGH = 16'd500;
	localparam logic [TIMER_BITS-1:0] RST_SYNC_LOW  = 16'd13000;
	localparam logic [REP_BITS-1:0]   RST_REPEATS   = 4'd10;
	localparam logic [LEN_BITS-1:0]   RST_CODE_LEN  = 5'd24;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BIT_HIGH,
		PH_BIT_LOW,
		PH_SYNC_HIGH,
		PH_SYNC_LOW
	} phase_t;

	typedef struct packed {
		logic                     command;
		logic [MAX_CODE_BITS-1:0] code_word;
		logic                     tick;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic done_res;
	} out_item_t;

endpackage

FILE: rtl/ookpw_out_skid.sv
// ----------------------------------------------------------------------------
// ookpw_out_skid
// Output register with a skid entry; stall toward the core is registered.
// ----------------------------------------------------------------------------
module ookpw_out_skid import ookpw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      full,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic      out_valid_q;
	out_item_t out_data_q;
	logic      skid_valid_q;
	out_item_t skid_data_q;
	logic      pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

endmodule

FILE: rtl/ook_pulse_width_code_transmitter_core.sv
// ----------------------------------------------------------------------------
// ook_pulse_width_code_transmitter_core
// Pulse-width code transmitter for an on-off keyed remote switch data line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one item per cycle while
//   in_stall is low; each item carries a start command, a 24-bit code word
//   and a tick flag. The phase timer advances one count per item whose tick is set.
//   Output channel (out_valid/out_stall/out_data) returns exactly one item
//   per input transaction: line level, busy and done, showing the state
//   after that input item.
//   Each result is registered in the output stage. Throughput is one item
//   per cycle while in_stall is low; the phase, timer, bit position and
//   repeat counter all update in the cycle the item is taken.
//   The output side has an output register plus one skid entry, so an input
//   is still taken while one result waits; in_stall rises once both are
//   occupied, i.e. right after a stalled cycle that also takes an input.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   writes should only happen while idle.
//   Reset puts the block idle with the line low and all registers at their
//   default timing (1200/500, 350/1300, 500/13000 ticks, 10 frames, 24 bits).
// ----------------------------------------------------------------------------
module ook_pulse_width_code_transmitter_core import ookpw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_item_t                in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output out_item_t               out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [TIMER_BITS-1:0]   cfg_data
);

	logic [TIMER_BITS-1:0] one_high_q, one_low_q, zero_high_q, zero_low_q;
	logic [TIMER_BITS-1:0] sync_high_q, sync_low_q;
	logic [REP_BITS-1:0]   repeats_cfg_q;
	logic [LEN_BITS-1:0]   code_len_q;

	phase_t                   phase_q, phase_d;
	logic [TIMER_BITS-1:0]    timer_q, timer_d;
	logic [POS_BITS-1:0]      pos_q, pos_d;
	logic [REP_BITS-1:0]      reps_q, reps_d;
	logic [MAX_CODE_BITS-1:0] code_q, code_d;

	logic                  accept;
	logic                  full;
	logic                  done;
	logic                  cur_bit;
	logic [TIMER_BITS-1:0] dur_raw;
	logic [TIMER_BITS:0]   dur_eff;
	logic [TIMER_BITS:0]   timer_inc;
	logic [POS_BITS-1:0]   start_pos;
	logic [REP_BITS-1:0]   reps_dec;
	out_item_t             result;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = full;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q    <= RST_ONE_HIGH;
			one_low_q     <= RST_ONE_LOW;
			zero_high_q   <= RST_ZERO_HIGH;
			zero_low_q    <= RST_ZERO_LOW;
			sync_high_q   <= RST_SYNC_HIGH;
			sync_low_q    <= RST_SYNC_LOW;
			repeats_cfg_q <= RST_REPEATS;
			code_len_q    <= RST_CODE_LEN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ONE_HIGH:  one_high_q    <= cfg_data;
				REG_ONE_LOW:   one_low_q     <= cfg_data;
				REG_ZERO_HIGH: zero_high_q   <= cfg_data;
				REG_ZERO_LOW:  zero_low_q    <= cfg_data;
				REG_SYNC_HIGH: sync_high_q   <= cfg_data;
				REG_SYNC_LOW:  sync_low_q    <= cfg_data;
				REG_REPEATS:   repeats_cfg_q <= cfg_data[REP_BITS-1:0];
				REG_CODE_LEN:  code_len_q    <= cfg_data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// First bit position of a frame: length clamped to 1..MAX_CODE_BITS
	always_comb begin
		if (code_len_q == '0) begin
			start_pos = '0;
		end else if ({1'b0, code_len_q} > (LEN_BITS+1)'(MAX_CODE_BITS)) begin
			start_pos = POS_BITS'(MAX_CODE_BITS - 1);
		end else begin
			start_pos = POS_BITS'(code_len_q - 1'b1);
		end
	end

	assign cur_bit = code_q[pos_q];

	always_comb begin
		case (phase_q)
			PH_BIT_HIGH:  dur_raw = cur_bit ? one_high_q : zero_high_q;
			PH_BIT_LOW:   dur_raw = cur_bit ? one_low_q : zero_low_q;
			PH_SYNC_HIGH: dur_raw = sync_high_q;
			default:      dur_raw = sync_low_q;
		endcase
	end

	// A zero duration counts as one tick
	assign dur_eff   = (dur_raw == '0) ? (TIMER_BITS+1)'(1) : {1'b0, dur_raw};
	assign timer_inc = {1'b0, timer_q} + 1'b1;
	assign reps_dec  = (reps_q != '0) ? reps_q - 1'b1 : reps_q;

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		pos_d   = pos_q;
		reps_d  = reps_q;
		code_d  = code_q;
		done    = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (in_data.command) begin
				code_d  = in_data.code_word;
				reps_d  = (repeats_cfg_q == '0) ? REP_BITS'(1) : repeats_cfg_q;
				pos_d   = start_pos;
				timer_d = '0;
				phase_d = PH_BIT_HIGH;
			end
		end else if (in_data.tick) begin
			timer_d = timer_inc[TIMER_BITS-1:0];
			if (timer_inc >= dur_eff) begin
				timer_d = '0;
				case (phase_q)
					PH_BIT_HIGH: phase_d = PH_BIT_LOW;
					PH_BIT_LOW: begin
						if (pos_q == '0) begin
							phase_d = PH_SYNC_HIGH;
						end else begin
							pos_d   = pos_q - 1'b1;
							phase_d = PH_BIT_HIGH;
						end
					end
					PH_SYNC_HIGH: phase_d = PH_SYNC_LOW;
					default: begin
						reps_d = reps_dec;
						if (reps_dec == '0) begin
							phase_d = PH_IDLE;
							pos_d   = '0;
							done    = 1'b1;
						end else begin
							pos_d   = start_pos;
							phase_d = PH_BIT_HIGH;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			pos_q   <= '0;
			reps_q  <= '0;
			code_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			pos_q   <= pos_d;
			reps_q  <= reps_d;
			code_q  <= code_d;
		end
	end

	assign result.line_level = (phase_d == PH_BIT_HIGH) || (phase_d == PH_SYNC_HIGH);
	assign result.busy_res   = (phase_d != PH_IDLE);
	assign result.done_res   = done;

	ookpw_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
